@@ rtl/core/sfr_pkg.sv @@
// Package: shared types, constants and the CRC16 byte update for the frame receiver.
`default_nettype none
package sfr_pkg;

	// Capacity limit on payload length, applied together with the max_payload register
	localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

	// CRC16 polynomial, MSB first
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_COMMAND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NACK_COMMAND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 3'd4;
	localparam int CFG_DATA_W = 16;

	// Configuration register reset values
	localparam logic [7:0] RST_START_BYTE = 8'h00;
	localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1024;
	localparam logic [7:0] RST_ACK_COMMAND = 8'h00;
	localparam logic [7:0] RST_NACK_COMMAND = 8'h01;
	localparam logic [15:0] RST_CRC_INIT = 16'hFFFF;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [15:0] max_payload;
		logic [7:0] ack_command;
		logic [7:0] nack_command;
		logic [15:0] crc_init;
	} cfg_t;

	// Parser phase of the front end
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_CMD = 3'd3,
		PH_SEQ = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CRC_LO = 3'd6,
		PH_CRC_HI = 3'd7
	} phase_t;

	// Work handed from front to back
	typedef enum logic [1:0] {
		OP_CMD = 2'd0,
		OP_SEQ = 2'd1,
		OP_DATA = 2'd2,
		OP_CHECK = 2'd3
	} op_kind_t;

	// Result kinds
	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_ACCEPTED = 2'd1,
		EV_IGNORED = 2'd2,
		EV_CRC_ERROR = 2'd3
	} event_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [7:0] data;
		logic [15:0] index;
		logic [7:0] command;
		logic [7:0] seq_num;
		logic [15:0] length;
		logic [15:0] rx_crc;
	} op_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0] pbyte;
		logic [15:0] pindex;
		logic [7:0] command;
		logic [7:0] seq_num;
		logic [15:0] length;
		logic [7:0] reply;
	} res_t;

	// One byte of CRC16, bitwise over eight steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/sfr_front.sv @@
// Front end: tracks the frame phase per received byte and posts CRC and result work.
`default_nettype none
module sfr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire sfr_pkg::cfg_t cfg,
	input wire logic push,
	input wire logic [7:0] rx_byte,
	input wire logic q_full,
	output logic q_push,
	output sfr_pkg::op_t q_op
);
	import sfr_pkg::*;

	phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] crc_lo_q, crc_lo_d;
	logic accept;
	logic [15:0] len_full;
	logic [15:0] limit;
	logic [15:0] pos_inc;

	assign accept = push && !q_full;
	assign len_full = {rx_byte, len_q[7:0]};
	assign limit = (cfg.max_payload < MAX_PAYLOAD) ? cfg.max_payload : MAX_PAYLOAD;
	assign pos_inc = pos_q + 16'd1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q <= '0;
			pos_q <= '0;
			cmd_q <= '0;
			seq_q <= '0;
			crc_lo_q <= '0;
		end else begin
			phase_q <= phase_d;
			len_q <= len_d;
			pos_q <= pos_d;
			cmd_q <= cmd_d;
			seq_q <= seq_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	// Next phase and work posting
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		pos_d = pos_q;
		cmd_d = cmd_q;
		seq_d = seq_q;
		crc_lo_d = crc_lo_q;
		q_push = 1'b0;
		q_op.kind = OP_CMD;
		q_op.data = rx_byte;
		q_op.index = pos_q;
		q_op.command = cmd_q;
		q_op.seq_num = seq_q;
		q_op.length = len_q;
		q_op.rx_crc = {rx_byte, crc_lo_q};
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == cfg.start_byte) begin
						phase_d = PH_LEN_LO;
						pos_d = '0;
					end
				end
				PH_LEN_LO: begin
					len_d = {8'h00, rx_byte};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d = len_full;
					// oversize length drops back to hunting without a result
					phase_d = (len_full > limit) ? PH_HUNT : PH_CMD;
				end
				PH_CMD: begin
					cmd_d = rx_byte;
					q_push = 1'b1;
					q_op.kind = OP_CMD;
					phase_d = PH_SEQ;
				end
				PH_SEQ: begin
					seq_d = rx_byte;
					pos_d = '0;
					q_push = 1'b1;
					q_op.kind = OP_SEQ;
					phase_d = (len_q != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
				end
				PH_PAYLOAD: begin
					q_push = 1'b1;
					q_op.kind = OP_DATA;
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					crc_lo_d = rx_byte;
					phase_d = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					q_push = 1'b1;
					q_op.kind = OP_CHECK;
					phase_d = PH_HUNT;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sfr_queue.sv @@
// Short FIFO of work items between the front and the back.
`default_nettype none
module sfr_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire sfr_pkg::op_t wr_op,
	output logic full,
	input wire logic rd_en,
	output logic rd_valid,
	output sfr_pkg::op_t rd_op
);
	import sfr_pkg::*;

	op_t store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sfr_back.sv @@
// Back end: runs the CRC, forms payload and status results, holds the output register.
`default_nettype none
module sfr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire sfr_pkg::cfg_t cfg,
	input wire logic q_valid,
	input wire sfr_pkg::op_t q_op,
	output logic q_pop,
	input wire logic pop,
	output logic res_valid,
	output sfr_pkg::res_t res
);
	import sfr_pkg::*;

	logic [15:0] crc_q, crc_d;
	logic [7:0] txseq_q, txseq_d;
	logic res_valid_q;
	res_t res_q, res_d;
	logic produces;
	logic out_free;
	logic [15:0] crc_base;
	logic [15:0] crc_upd;
	logic is_ackish;

	assign res_valid = res_valid_q;
	assign res = res_q;

	// Issue: ops without a result never wait on the output register
	assign produces = (q_op.kind == OP_DATA) || (q_op.kind == OP_CHECK);
	assign out_free = !res_valid_q || pop;
	assign q_pop = q_valid && (!produces || out_free);

	assign crc_base = (q_op.kind == OP_CMD) ? cfg.crc_init : crc_q;
	assign crc_upd = crc16_byte(crc_base, q_op.data);
	assign is_ackish = (q_op.command == cfg.ack_command) || (q_op.command == cfg.nack_command);

	// Execute one op
	always_comb begin
		crc_d = crc_q;
		txseq_d = txseq_q;
		res_d.kind = EV_PAYLOAD;
		res_d.pbyte = 8'h00;
		res_d.pindex = 16'h0000;
		res_d.command = q_op.command;
		res_d.seq_num = q_op.seq_num;
		res_d.length = q_op.length;
		res_d.reply = 8'h00;
		unique case (q_op.kind)
			OP_CMD, OP_SEQ: begin
				crc_d = crc_upd;
			end
			OP_DATA: begin
				crc_d = crc_upd;
				res_d.kind = EV_PAYLOAD;
				res_d.pbyte = q_op.data;
				res_d.pindex = q_op.index;
			end
			OP_CHECK: begin
				if (q_op.rx_crc != crc_q) begin
					res_d.kind = EV_CRC_ERROR;
					res_d.reply = txseq_q;
					txseq_d = txseq_q + 8'd1;
				end else if (is_ackish) begin
					res_d.kind = EV_IGNORED;
				end else begin
					res_d.kind = EV_ACCEPTED;
					res_d.reply = txseq_q;
					txseq_d = txseq_q + 8'd1;
				end
			end
			default: begin
				crc_d = crc_q;
			end
		endcase
	end

	// CRC and transmit sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			txseq_q <= '0;
		end else if (q_pop) begin
			crc_q <= crc_d;
			txseq_q <= txseq_d;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (q_pop && produces) begin
			res_q <= res_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && produces) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/serial_frame_receiver_crc_check_core.sv @@
// Top level: framed byte receiver with CRC16 check, configuration registers and assertions.
// Path: a payload or final CRC byte accepted by the parser is written into the queue, then
// taken into the output register before it shows on the result ports; a result stall holds it.
// Throughput: one byte per cycle while the queue is not full; the byte-wise CRC update in the back end sets the pace.
// A four-entry queue separates parser and CRC unit, and one output register holds a result.
// Reset (arst_n low) clears parser, queue and output valid and loads register defaults.
`default_nettype none
module serial_frame_receiver_crc_check_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic push,
	output logic full,
	input wire logic [7:0] rx_byte,
	output logic empty,
	input wire logic pop,
	output logic [1:0] event_kind,
	output logic [7:0] payload_byte,
	output logic [15:0] payload_index,
	output logic [7:0] frame_command,
	output logic [7:0] frame_sequence,
	output logic [15:0] frame_length,
	output logic [7:0] reply_sequence
);
	import sfr_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	op_t q_wr_op;
	logic q_full;
	logic q_pop;
	logic q_valid;
	op_t q_rd_op;
	logic res_valid;
	res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= RST_START_BYTE;
			cfg_q.max_payload <= RST_MAX_PAYLOAD;
			cfg_q.ack_command <= RST_ACK_COMMAND;
			cfg_q.nack_command <= RST_NACK_COMMAND;
			cfg_q.crc_init <= RST_CRC_INIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_START_BYTE: cfg_q.start_byte <= cfg_data[7:0];
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				CFG_ACK_COMMAND: cfg_q.ack_command <= cfg_data[7:0];
				CFG_NACK_COMMAND: cfg_q.nack_command <= cfg_data[7:0];
				CFG_CRC_INIT: cfg_q.crc_init <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	sfr_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_q),
		.push (push),
		.rx_byte (rx_byte),
		.q_full (q_full),
		.q_push (q_push),
		.q_op (q_wr_op)
	);

	sfr_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (q_push),
		.wr_op (q_wr_op),
		.full (q_full),
		.rd_en (q_pop),
		.rd_valid (q_valid),
		.rd_op (q_rd_op)
	);

	sfr_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_q),
		.q_valid (q_valid),
		.q_op (q_rd_op),
		.q_pop (q_pop),
		.pop (pop),
		.res_valid (res_valid),
		.res (res)
	);

	// Result ports
	assign full = q_full;
	assign empty = !res_valid;
	assign event_kind = res.kind;
	assign payload_byte = res.pbyte;
	assign payload_index = res.pindex;
	assign frame_command = res.command;
	assign frame_sequence = res.seq_num;
	assign frame_length = res.length;
	assign reply_sequence = res.reply;

	// Checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue written while full");

	a_payload_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == EV_PAYLOAD) |-> (payload_index < frame_length))
		else $error("payload index beyond frame length");

	a_status_clean_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != EV_PAYLOAD) |-> (payload_byte == 8'h00 && payload_index == 16'h0000))
		else $error("status result carries payload fields");

	a_ignored_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == EV_IGNORED) |-> (reply_sequence == 8'h00))
		else $error("ignored ack/nack carries a reply sequence");

endmodule
`default_nettype wire
